// ----- sv/ahcp_pkg.sv -----
// ahcp_pkg: shared types, constants and helper functions for the altitude hold controller
// no dependencies; imported by ahcp_mul, ahcp_seq, altitude_hold_cascaded_pid and the testbench
package ahcp_pkg;

	// limits and scales of the cascaded loops
	localparam int LEVEL_LIMIT   = 800;
	localparam int ALT_ERR_LIMIT = 500;
	localparam int ALT_DEADBAND  = 10;
	localparam int SPEED_LIMIT   = 300;
	localparam int ALT_P_SHIFT   = 7;     // divide by 128
	localparam int VEL_PD_SHIFT  = 9;     // divide by 512
	localparam int VEL_I_SHIFT   = 13;    // divide by 8192
	localparam int I_TERM_LIMIT  = 200;
	localparam int INTEG_LIMIT   = (1 << VEL_I_SHIFT) * I_TERM_LIMIT;
	localparam int D_LIMIT       = 150;

	// datapath widths
	localparam int GAIN_W  = 8;
	localparam int OPND_W  = 17;
	localparam int PROD_W  = GAIN_W + 1 + OPND_W;
	localparam int INTEG_W = 22;
	localparam int ADJ_W   = 11;

	// register indexes
	localparam logic [7:0] REG_ALT_P = 8'd0;
	localparam logic [7:0] REG_VEL_P = 8'd1;
	localparam logic [7:0] REG_VEL_I = 8'd2;
	localparam logic [7:0] REG_VEL_D = 8'd3;

	// register reset values
	localparam logic [GAIN_W-1:0] ALT_P_RST = 8'd50;
	localparam logic [GAIN_W-1:0] VEL_P_RST = 8'd120;
	localparam logic [GAIN_W-1:0] VEL_I_RST = 8'd45;
	localparam logic [GAIN_W-1:0] VEL_D_RST = 8'd1;

	// multiplier operand selection
	typedef enum logic [1:0] {
		MUL_ALT,
		MUL_VEL_P,
		MUL_VEL_I,
		MUL_VEL_D
	} mul_sel_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALT,
		ST_VERR,
		ST_MP,
		ST_MI,
		ST_MD,
		ST_FIN,
		ST_OUT
	} seq_state_t;

	// sequencer to datapath controls
	typedef struct packed {
		mul_sel_t mul_sel;
		logic     ld_err;
		logic     ld_p;
		logic     ld_integ;
		logic     ld_adj;
		logic     out_load;
	} ctrl_t;

	// signed divide by 2**k, truncating toward zero
	function automatic logic signed [PROD_W-1:0] div_pow2(
		input logic signed [PROD_W-1:0] x,
		input int unsigned              k
	);
		logic signed [PROD_W-1:0] bias;
		bias = x[PROD_W-1] ? ((PROD_W'(1) <<< k) - PROD_W'(1)) : '0;
		return (x + bias) >>> k;
	endfunction

	// symmetric saturation to +-lim
	function automatic logic signed [PROD_W-1:0] sat(
		input logic signed [PROD_W-1:0] x,
		input int                       lim
	);
		logic signed [PROD_W-1:0] l;
		l = PROD_W'(lim);
		if (x > l)
			return l;
		else if (x < -l)
			return -l;
		return x;
	endfunction

endpackage

// ----- sv/altitude_hold_cascaded_pid.sv -----
// altitude_hold_cascaded_pid: altitude P stage cascaded into a vertical speed PID
// depends on ahcp_pkg, ahcp_mul, ahcp_seq
//
//  channel  signals                                  direction  notes
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  in         always ready, index 0..3
//  in       in_valid/in_ready, eight update fields     in         one update per transfer
//  out      out_valid/out_ready, throttle_adjust,      out        one result per update
//           level_ok
//
// after its input transfer a level update goes through the altitude pass of the single gain
// multiplier and its product register, the speed error, the P, I and D passes, the final
// sum and the output load, which waits until the output register is free
// a tilted update skips the loops and goes straight to the output load
// the block takes no new update until the result has left for the output register
// reset restores the default gains and zeroes the integrator and previous acceleration
module altitude_hold_cascaded_pid (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [7:0]                          cfg_index,
	input  logic [ahcp_pkg::GAIN_W-1:0]         cfg_data,
	// input items
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [23:0]                  target_altitude,
	input  logic signed [23:0]                  estimated_altitude,
	input  logic signed [15:0]                  estimated_speed,
	input  logic signed [10:0]                  speed_command,
	input  logic signed [11:0]                  roll_angle,
	input  logic signed [11:0]                  pitch_angle,
	input  logic signed [15:0]                  vertical_accel,
	input  logic                                clear_integrator,
	// results
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [ahcp_pkg::ADJ_W-1:0]   throttle_adjust,
	output logic                                level_ok
);
	import ahcp_pkg::*;

	ctrl_t                      ctrl;
	logic                       in_fire;
	logic                       out_free;
	logic                       level_now;

	logic [GAIN_W-1:0]          alt_p_q, vel_p_q, vel_i_q, vel_d_q;
	logic signed [23:0]         tgt_q, est_q;
	logic signed [15:0]         spd_q;
	logic signed [10:0]         cmd_q;
	logic signed [OPND_W-1:0]   accsum_q;
	logic signed [15:0]         prev_acc_q;
	logic                       level_q;
	logic signed [INTEG_W-1:0]  integ_q;
	logic signed [OPND_W-1:0]   err_q;
	logic signed [9:0]          p_q;
	logic signed [ADJ_W-1:0]    adj_q;
	logic                       out_valid_q;

	logic [GAIN_W-1:0]          mul_gain;
	logic signed [OPND_W-1:0]   mul_opnd;
	logic signed [PROD_W-1:0]   prod_q;

	logic signed [24:0]         alt_diff;
	logic signed [9:0]          alt_err;
	logic signed [9:0]          alt_db;
	logic signed [PROD_W-1:0]   vq_full;
	logic signed [10:0]         vcmd;
	logic signed [PROD_W-1:0]   p_full;
	logic signed [PROD_W:0]     integ_sum;
	logic signed [INTEG_W-1:0]  integ_new;
	logic signed [INTEG_W-1:0]  i_bias;
	logic signed [INTEG_W-1:0]  i_full;
	logic signed [PROD_W-1:0]   d_full;
	logic signed [ADJ_W:0]      adj_sum;

	assign in_fire   = in_valid & in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	// level check on the incoming attitude
	assign level_now = (roll_angle < 12'sd800) && (roll_angle > -12'sd800) &&
		(pitch_angle < 12'sd800) && (pitch_angle > -12'sd800);

	ahcp_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.level    (level_now),
		.out_free (out_free),
		.in_ready (in_ready),
		.ctrl     (ctrl)
	);

	// gain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alt_p_q <= ALT_P_RST;
			vel_p_q <= VEL_P_RST;
			vel_i_q <= VEL_I_RST;
			vel_d_q <= VEL_D_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ALT_P: alt_p_q <= cfg_data;
				REG_VEL_P: vel_p_q <= cfg_data;
				REG_VEL_I: vel_i_q <= cfg_data;
				REG_VEL_D: vel_d_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured update fields
	always_ff @(posedge clk) begin
		if (in_fire) begin
			tgt_q    <= target_altitude;
			est_q    <= estimated_altitude;
			spd_q    <= estimated_speed;
			cmd_q    <= speed_command;
			accsum_q <= OPND_W'(vertical_accel) + OPND_W'(prev_acc_q);
		end
	end

	// altitude error: clamp then deadband
	always_comb begin
		alt_diff = 25'(tgt_q) - 25'(est_q);
		if (alt_diff > 25'sd500)
			alt_err = 10'sd500;
		else if (alt_diff < -25'sd500)
			alt_err = -10'sd500;
		else
			alt_err = alt_diff[9:0];
		if (alt_err < 10'sd10 && alt_err > -10'sd10)
			alt_db = '0;
		else if (alt_err > 10'sd0)
			alt_db = alt_err - 10'sd10;
		else
			alt_db = alt_err + 10'sd10;
	end

	// shared multiplier operand selection
	always_comb begin
		unique case (ctrl.mul_sel)
			MUL_ALT: begin
				mul_gain = alt_p_q;
				mul_opnd = OPND_W'(alt_db);
			end
			MUL_VEL_P: begin
				mul_gain = vel_p_q;
				mul_opnd = err_q;
			end
			MUL_VEL_I: begin
				mul_gain = vel_i_q;
				mul_opnd = err_q;
			end
			MUL_VEL_D: begin
				mul_gain = vel_d_q;
				mul_opnd = accsum_q;
			end
			default: begin
				mul_gain = alt_p_q;
				mul_opnd = OPND_W'(alt_db);
			end
		endcase
	end

	ahcp_mul u_mul (
		.clk    (clk),
		.gain   (mul_gain),
		.opnd   (mul_opnd),
		.prod_q (prod_q)
	);

	// post-product scaling and term assembly
	always_comb begin
		vq_full   = sat(div_pow2(prod_q, ALT_P_SHIFT), SPEED_LIMIT);
		vcmd      = (cmd_q == 11'sd0) ? vq_full[10:0] : cmd_q;
		p_full    = sat(div_pow2(prod_q, VEL_PD_SHIFT), SPEED_LIMIT);
		integ_sum = (PROD_W + 1)'(integ_q) + (PROD_W + 1)'(prod_q);
		if (integ_sum > (PROD_W + 1)'(INTEG_LIMIT))
			integ_new = INTEG_W'(INTEG_LIMIT);
		else if (integ_sum < -(PROD_W + 1)'(INTEG_LIMIT))
			integ_new = -INTEG_W'(INTEG_LIMIT);
		else
			integ_new = integ_sum[INTEG_W-1:0];
		i_bias    = integ_q[INTEG_W-1] ? INTEG_W'((1 << VEL_I_SHIFT) - 1) : '0;
		i_full    = (integ_q + i_bias) >>> VEL_I_SHIFT;
		d_full    = sat(div_pow2(prod_q, VEL_PD_SHIFT), D_LIMIT);
		adj_sum   = (ADJ_W + 1)'(p_q) + (ADJ_W + 1)'($signed(i_full[8:0])) -
			(ADJ_W + 1)'($signed(d_full[8:0]));
	end

	// working registers of the loops
	always_ff @(posedge clk) begin
		if (in_fire)
			level_q <= level_now;
		if (ctrl.ld_err)
			err_q <= OPND_W'(vcmd) - OPND_W'(spd_q);
		if (ctrl.ld_p)
			p_q <= p_full[9:0];
		if (in_fire)
			adj_q <= '0;
		else if (ctrl.ld_adj)
			adj_q <= adj_sum[ADJ_W-1:0];
	end

	// loop state: integrator and previous acceleration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			prev_acc_q <= '0;
		end else begin
			if (in_fire) begin
				prev_acc_q <= vertical_accel;
				if (clear_integrator)
					integ_q <= '0;
			end else if (ctrl.ld_integ) begin
				integ_q <= integ_new;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctrl.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			throttle_adjust <= adj_q;
			level_ok        <= level_q;
		end
	end

	assign out_valid = out_valid_q;

	// a tilted result carries no correction
	a_tilt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !level_ok |-> throttle_adjust == '0)
		else $error("tilted result with nonzero throttle adjustment");

	// adjustment stays within the sum of the term limits
	a_adj_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (throttle_adjust <= 11'sd650) && (throttle_adjust >= -11'sd650))
		else $error("throttle adjustment out of range");

	// integrator stays within its clamp
	a_integ_range: assert property (@(posedge clk) disable iff (!arst_n)
		(integ_q <= INTEG_W'(INTEG_LIMIT)) && (integ_q >= -INTEG_W'(INTEG_LIMIT)))
		else $error("integrator beyond its limit");

	// no new update is taken while one is in progress
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input accepted while busy");

	// a result is only loaded when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten before transfer");

endmodule

// ----- sv/ahcp_mul.sv -----
// ahcp_mul: shared gain multiplier with registered product
// depends on ahcp_pkg
module ahcp_mul (
	input  logic                                clk,
	input  logic [ahcp_pkg::GAIN_W-1:0]         gain,
	input  logic signed [ahcp_pkg::OPND_W-1:0]  opnd,
	output logic signed [ahcp_pkg::PROD_W-1:0]  prod_q
);
	import ahcp_pkg::*;

	logic signed [GAIN_W:0] gain_s;

	// unsigned gain as a non-negative signed operand
	assign gain_s = $signed({1'b0, gain});

	// product register
	always_ff @(posedge clk) begin
		prod_q <= gain_s * opnd;
	end

endmodule

// ----- sv/ahcp_seq.sv -----
// ahcp_seq: sequencer stepping one update through the shared multiplier
// depends on ahcp_pkg
module ahcp_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  logic            level,
	input  logic            out_free,
	output logic            in_ready,
	output ahcp_pkg::ctrl_t ctrl
);
	import ahcp_pkg::*;

	seq_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and controls
	always_comb begin
		state_d       = state_q;
		ctrl          = '0;
		ctrl.mul_sel  = MUL_ALT;
		in_ready      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_fire)
					state_d = level ? ST_ALT : ST_OUT;
			end
			ST_ALT: begin
				ctrl.mul_sel = MUL_ALT;
				state_d      = ST_VERR;
			end
			ST_VERR: begin
				ctrl.ld_err = 1'b1;
				state_d     = ST_MP;
			end
			ST_MP: begin
				ctrl.mul_sel = MUL_VEL_P;
				state_d      = ST_MI;
			end
			ST_MI: begin
				ctrl.mul_sel = MUL_VEL_I;
				ctrl.ld_p    = 1'b1;
				state_d      = ST_MD;
			end
			ST_MD: begin
				ctrl.mul_sel  = MUL_VEL_D;
				ctrl.ld_integ = 1'b1;
				state_d       = ST_FIN;
			end
			ST_FIN: begin
				ctrl.ld_adj = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					ctrl.out_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- bench/testbench.sv -----
// testbench for altitude_hold_cascaded_pid: directed and random control updates, checked
// against a cycle-free predictor of the cascaded altitude and vertical speed loops
// depends on ahcp_pkg (register indexes, widths) and the altitude_hold_cascaded_pid rtl
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ahcp_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int QUIET_LIMIT = 3000;   // cycles with no transfer of any kind
	localparam int SETTLE      = 16;
	localparam int HOLD_AT     = 250;    // results seen before the long output hold
	localparam int HOLD_LEN    = 300;
	localparam int MAX_PRINTS  = 40;

	// loop limits and scales
	localparam longint TILT_LIMIT   = 800;
	localparam longint ALT_ERR_CLIP = 500;
	localparam longint DEAD_ZONE    = 10;
	localparam longint SPEED_CLIP   = 300;
	localparam longint ALT_P_DIV    = 128;
	localparam longint PD_DIV       = 512;
	localparam longint I_DIV        = 8192;
	localparam longint INTEG_CLIP   = 8192 * 200;
	localparam longint D_CLIP       = 150;

	// indexes outside the register list, written to check they are ignored
	localparam logic [7:0] REG_SPARE = 8'd4;
	localparam logic [7:0] REG_TOP   = 8'hFF;

	typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_MOSTLY} rx_pattern_t;

	typedef struct {
		logic signed [23:0] tgt;
		logic signed [23:0] est;
		logic signed [15:0] spd;
		logic signed [10:0] cmd;
		logic signed [11:0] roll;
		logic signed [11:0] pitch;
		logic signed [15:0] acc;
		logic               clr;
	} update_t;

	typedef struct {
		logic signed [ADJ_W-1:0] adj;
		logic                    lvl;
	} adjust_t;

	// predicts each throttle adjustment and holds them until the block delivers them
	class adjust_ledger;
		bit [7:0]           alt_gain = 8'd50;
		bit [7:0]           vp_gain  = 8'd120;
		bit [7:0]           vi_gain  = 8'd45;
		bit [7:0]           vd_gain  = 8'd1;
		logic signed [21:0] integ_q  = '0;
		logic signed [15:0] prev_acc = '0;
		adjust_t            pending_adjust[$];
		int errors, n_updates, n_tilted, n_alt_stage, n_clears, n_results, n_writes;

		function longint clip(longint v, longint lim);
			if (v > lim)
				return lim;
			if (v < -lim)
				return -lim;
			return v;
		endfunction

		function longint dead_zone(longint v);
			if (v < DEAD_ZONE && v > -DEAD_ZONE)
				return 0;
			return (v > 0) ? v - DEAD_ZONE : v + DEAD_ZONE;
		endfunction

		function void set_gain(logic [7:0] idx, logic [7:0] val);
			n_writes++;
			case (idx)
				REG_ALT_P: alt_gain = val;
				REG_VEL_P: vp_gain  = val;
				REG_VEL_I: vi_gain  = val;
				REG_VEL_D: vd_gain  = val;
				default: ;
			endcase
		endfunction

		function void note_update(update_t u);
			longint  roll, pitch, alt_err, speed_cmd, speed_err, integ, sum;
			bit      lvl;
			adjust_t e;
			roll  = longint'(u.roll);
			pitch = longint'(u.pitch);
			n_updates++;
			if (u.clr) begin
				integ_q = '0;
				n_clears++;
			end
			lvl = roll < TILT_LIMIT && roll > -TILT_LIMIT &&
				pitch < TILT_LIMIT && pitch > -TILT_LIMIT;
			sum = 0;
			if (lvl) begin
				// altitude stage only when the pilot asks for no climb rate
				if (u.cmd == 0) begin
					n_alt_stage++;
					alt_err = clip(longint'(u.tgt) - longint'(u.est), ALT_ERR_CLIP);
					alt_err = dead_zone(alt_err);
					speed_cmd = clip(longint'(alt_gain) * alt_err / ALT_P_DIV, SPEED_CLIP);
				end else begin
					speed_cmd = longint'(u.cmd);
				end
				// speed loop: p, clamped integrator, d on summed accelerations
				speed_err = speed_cmd - longint'(u.spd);
				sum = clip(longint'(vp_gain) * speed_err / PD_DIV, SPEED_CLIP);
				integ = clip(longint'(integ_q) + longint'(vi_gain) * speed_err, INTEG_CLIP);
				integ_q = integ[21:0];
				sum += integ / I_DIV;
				sum -= clip(longint'(vd_gain) * (longint'(u.acc) + longint'(prev_acc)) / PD_DIV,
					D_CLIP);
			end else begin
				n_tilted++;
			end
			prev_acc = u.acc;
			e.adj = sum[ADJ_W-1:0];
			e.lvl = lvl;
			pending_adjust.push_back(e);
		endfunction

		task report(string what);
			errors++;
			if (errors <= MAX_PRINTS)
				$display("mismatch at %0t: %s", $time, what);
		endtask

		task check_result(logic signed [ADJ_W-1:0] adj, logic lvl);
			adjust_t e;
			n_results++;
			if (pending_adjust.size() == 0) begin
				report($sformatf("result adj=%0d level=%b with no update outstanding", adj, lvl));
			end else begin
				e = pending_adjust.pop_front();
				if (adj !== e.adj)
					report($sformatf("result %0d throttle_adjust %0d, expected %0d",
						n_results, adj, e.adj));
				if (lvl !== e.lvl)
					report($sformatf("result %0d level_ok %b, expected %b",
						n_results, lvl, e.lvl));
			end
		endtask

		function int waiting();
			return pending_adjust.size();
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [7:0]               cfg_index;
	logic [GAIN_W-1:0]        cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [23:0]       target_altitude;
	logic signed [23:0]       estimated_altitude;
	logic signed [15:0]       estimated_speed;
	logic signed [10:0]       speed_command;
	logic signed [11:0]       roll_angle;
	logic signed [11:0]       pitch_angle;
	logic signed [15:0]       vertical_accel;
	logic                     clear_integrator;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [ADJ_W-1:0]  throttle_adjust;
	logic                     level_ok;

	adjust_ledger book = new();
	update_t      stim_q[$];
	int           quiet;

	altitude_hold_cascaded_pid dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.target_altitude    (target_altitude),
		.estimated_altitude (estimated_altitude),
		.estimated_speed    (estimated_speed),
		.speed_command      (speed_command),
		.roll_angle         (roll_angle),
		.pitch_angle        (pitch_angle),
		.vertical_accel     (vertical_accel),
		.clear_integrator   (clear_integrator),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.throttle_adjust    (throttle_adjust),
		.level_ok           (level_ok)
	);

	// clock
	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1)
			book.check_result(throttle_adjust, level_ok);
	end

	// watchdog on cycles with no transfer on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				quiet, book.waiting());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: changing stall patterns, plus one long hold while updates keep coming
	initial begin : receiver
		rx_pattern_t pattern;
		int          span;
		int          hold;
		bit          held;
		logic        rdy;
		pattern = RX_OPEN;
		span    = 0;
		hold    = 0;
		held    = 1'b0;
		out_ready <= 1'b0;
		@(posedge clk iff arst_n === 1'b1);
		forever begin
			if (span == 0) begin
				pattern = rx_pattern_t'($urandom_range(0, 3));
				span    = $urandom_range(20, 80);
			end
			span--;
			if (!held && book.n_results >= HOLD_AT) begin
				held = 1'b1;
				hold = HOLD_LEN;
			end
			if (hold > 0) begin
				hold--;
				rdy = 1'b0;
			end else begin
				case (pattern)
					RX_OPEN:         rdy = 1'b1;
					RX_COIN:         rdy = 1'($urandom_range(0, 1));
					RX_EVERY_FOURTH: rdy = (span % 4 == 0);
					default:         rdy = ($urandom_range(0, 7) != 0);
				endcase
			end
			out_ready <= rdy;
			@(posedge clk);
		end
	end

	// one register write; the caller lowers cfg_valid after its last write
	task automatic write_gain(input logic [7:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		book.set_gain(idx, val);
	endtask

	task automatic write_gains(input logic [7:0] ap, vp, vi, vd);
		write_gain(REG_ALT_P, ap);
		write_gain(REG_VEL_P, vp);
		write_gain(REG_VEL_I, vi);
		write_gain(REG_VEL_D, vd);
	endtask

	// one update transfer; valid stays high for the caller to continue a burst
	task automatic push_update(input update_t u);
		in_valid           <= 1'b1;
		target_altitude    <= u.tgt;
		estimated_altitude <= u.est;
		estimated_speed    <= u.spd;
		speed_command      <= u.cmd;
		roll_angle         <= u.roll;
		pitch_angle        <= u.pitch;
		vertical_accel     <= u.acc;
		clear_integrator   <= u.clr;
		do @(posedge clk); while (in_ready !== 1'b1);
		book.note_update(u);
	endtask

	// send the queued updates in bursts with random gaps
	task automatic send_all();
		int burst;
		int gap;
		burst = 0;
		while (stim_q.size() != 0) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 30);
				gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			push_update(stim_q.pop_front());
			burst--;
		end
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (book.waiting() != 0)
			@(posedge clk);
	endtask

	function automatic update_t mk(int tgt, int est, int spd, int cmd, int roll, int pitch,
		int acc, bit clr);
		update_t u;
		u.tgt   = 24'(tgt);
		u.est   = 24'(est);
		u.spd   = 16'(spd);
		u.cmd   = 11'(cmd);
		u.roll  = 12'(roll);
		u.pitch = 12'(pitch);
		u.acc   = 16'(acc);
		u.clr   = clr;
		return u;
	endfunction

	// mostly level flight with modest errors, some full-range noise
	function automatic update_t rand_update();
		update_t u;
		int      r;
		u.tgt = 24'($urandom);
		if ($urandom_range(0, 4) == 0)
			u.est = 24'($urandom);
		else
			u.est = 24'(int'(u.tgt) - (int'($urandom_range(0, 1400)) - 700));
		u.spd = 16'(($urandom_range(0, 9) < 6) ? int'($urandom_range(0, 1200)) - 600 :
			int'($urandom));
		r = $urandom_range(0, 9);
		if (r < 5)
			u.cmd = '0;
		else if (r < 8)
			u.cmd = 11'(int'($urandom_range(0, 800)) - 400);
		else
			u.cmd = 11'($urandom);
		r = $urandom_range(0, 19);
		u.roll = 12'((r < 17) ? int'($urandom_range(0, 1598)) - 799 :
			(r < 19) ? int'($urandom_range(0, 3600)) - 1800 : int'($urandom));
		r = $urandom_range(0, 19);
		u.pitch = 12'((r < 17) ? int'($urandom_range(0, 1598)) - 799 :
			(r < 19) ? int'($urandom_range(0, 3600)) - 1800 : int'($urandom));
		u.acc = 16'(($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 8000)) - 4000 :
			int'($urandom));
		u.clr = ($urandom_range(0, 19) == 0);
		return u;
	endfunction

	task automatic run_random(input int n);
		repeat (n) stim_q.push_back(rand_update());
		send_all();
		drain();
	endtask

	// main sequence
	initial begin
		arst_n             <= 1'b0;
		cfg_valid          <= 1'b0;
		cfg_index          <= '0;
		cfg_data           <= '0;
		in_valid           <= 1'b0;
		target_altitude    <= '0;
		estimated_altitude <= '0;
		estimated_speed    <= '0;
		speed_command      <= '0;
		roll_angle         <= '0;
		pitch_angle        <= '0;
		vertical_accel     <= '0;
		clear_integrator   <= 1'b0;
		quiet = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed updates at reset gains
		stim_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 1'b1));                  // hover, clear
		stim_q.push_back(mk(8388607, -8388608, 0, 0, 0, 0, 0, 1'b0));     // climb error clamps
		stim_q.push_back(mk(-8388608, 8388607, 0, 0, 0, 0, 0, 1'b0));     // sink error clamps
		stim_q.push_back(mk(1000, 991, 0, 0, 0, 0, 0, 1'b0));             // inside deadband
		stim_q.push_back(mk(1000, 990, 0, 0, 0, 0, 0, 1'b0));             // deadband edge
		stim_q.push_back(mk(1000, 989, 0, 0, 0, 0, 0, 1'b0));             // just outside
		stim_q.push_back(mk(-1000, -991, 0, 0, 0, 0, 0, 1'b0));
		stim_q.push_back(mk(-1000, -989, 0, 0, 0, 0, 0, 1'b0));
		stim_q.push_back(mk(0, 0, -32768, 1023, 0, 0, 0, 1'b0));          // largest speed error
		stim_q.push_back(mk(0, 0, -32768, 1023, 0, 0, 0, 1'b0));          // integrator saturates
		stim_q.push_back(mk(0, 0, 32767, -1024, 0, 0, 0, 1'b0));
		stim_q.push_back(mk(0, 0, 0, 1, 0, 0, 0, 1'b0));                  // smallest command
		stim_q.push_back(mk(0, 0, 0, 0, 800, 0, 32767, 1'b0));            // tilted roll
		stim_q.push_back(mk(0, 0, 0, 0, -800, 0, 32767, 1'b0));
		stim_q.push_back(mk(0, 0, 0, 0, 799, -799, 32767, 1'b0));         // level at the limit
		stim_q.push_back(mk(0, 0, 0, 0, 0, 0, -32768, 1'b0));
		stim_q.push_back(mk(0, 0, 0, 0, 0, 0, -32768, 1'b0));
		stim_q.push_back(mk(0, 0, 0, 0, 0, 800, 0, 1'b0));                // tilted pitch
		stim_q.push_back(mk(0, 0, 0, 0, 0, -800, 0, 1'b0));
		stim_q.push_back(mk(0, 0, 0, 0, 2047, -2048, 100, 1'b0));         // angles at the extremes of their range
		stim_q.push_back(mk(0, 0, 500, 0, 1800, -1800, 0, 1'b1));         // clear while tilted
		stim_q.push_back(mk(500, 0, 0, 0, -799, 799, -200, 1'b0));
		stim_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 1'b0));
		send_all();
		drain();

		// random phases, gains changed only while the block is idle
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: write_gains(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				1: begin
					write_gains(8'd0, 8'd0, 8'd0, 8'd0);
					write_gain(REG_SPARE, 8'($urandom));
				end
				2: begin
					write_gains(8'd255, 8'd255, 8'd255, 8'd255);
					write_gain(REG_TOP, 8'($urandom));
				end
				3: write_gains(8'd1, 8'd255, 8'd1, 8'd255);
				default: write_gains(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			cfg_valid <= 1'b0;
			@(posedge clk);
			run_random((phase == 1) ? 100 : (phase == 4) ? 200 : 150);
		end

		repeat (SETTLE) @(posedge clk);
		$display("ran %0d updates: %0d tilted, %0d through the altitude stage, %0d clears",
			book.n_updates, book.n_tilted, book.n_alt_stage, book.n_clears);
		$display("%0d register writes, %0d results checked, %0d mismatches",
			book.n_writes, book.n_results, book.errors);
		if (book.errors == 0 && book.waiting() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
